// File: sv/dtfp_pkg.sv
// ----------------------------------------------------------------------------
// dtfp_pkg
// Shared types and constants for the decimal text to fixed point core.
// ----------------------------------------------------------------------------
`default_nettype none

package dtfp_pkg;

    localparam logic [7:0] ASCII_ZERO  = 8'd48;
    localparam logic [7:0] ASCII_NINE  = 8'd57;
    localparam logic [7:0] ASCII_POINT = 8'h2E;

    // Job queue status seen by the front and back ends.
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_HOLD
    } back_state_t;

    // 10^n for n = 0..9.
    function automatic logic [31:0] pow_ten(input logic [3:0] n);
        logic [31:0] p;
        case (n)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = 32'd1000000000;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// File: sv/dtfp_ifs.sv
// ----------------------------------------------------------------------------
// dtfp_ifs
// Valid/ready channels: character requests in, fixed point results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtfp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface dtfp_result_if #(
    parameter int VALUE_W = 48
);
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] fixed_value;
    logic               overflowed;

    modport source (output valid, output fixed_value, output overflowed, input ready);
    modport sink   (input valid, input fixed_value, input overflowed, output ready);
endinterface

`default_nettype wire

// File: sv/dtfp_front.sv
// ----------------------------------------------------------------------------
// dtfp_front
// Character classifier and integer/fraction accumulators; pushes one job
// per string into the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dtfp_front #(
    parameter int INT_BITS        = 32,
    parameter int MAX_FRAC_DIGITS = 8,
    parameter int FACC_W          = 27,
    parameter int CNT_W           = 4,
    parameter int JOB_W           = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    dtfp_char_if.sink              char_chan,
    input  wire dtfp_pkg::q_status_t q_status,
    output logic                   push,
    output logic [JOB_W-1:0]       job
);

    logic [INT_BITS-1:0] int_acc_reg,  int_acc_next;
    logic [FACC_W-1:0]   frac_acc_reg, frac_acc_next;
    logic [CNT_W-1:0]    frac_cnt_reg, frac_cnt_next;
    logic                point_reg,    point_next;
    logic                ovf_reg,      ovf_next;

    logic                accept;
    logic                is_digit;
    logic                is_point;
    logic [3:0]          digit;
    logic [INT_BITS+3:0] int_wide;
    logic [FACC_W+3:0]   frac_wide;

    assign char_chan.ready = !q_status.full;
    assign accept          = char_chan.valid && char_chan.ready;

    assign is_point = (char_chan.char_code == dtfp_pkg::ASCII_POINT);
    assign is_digit = (char_chan.char_code >= dtfp_pkg::ASCII_ZERO) &&
                      (char_chan.char_code <= dtfp_pkg::ASCII_NINE);
    assign digit    = 4'(char_chan.char_code - dtfp_pkg::ASCII_ZERO);

    // acc*10 + d as two shifts and two adds
    assign int_wide  = ({4'd0, int_acc_reg} << 3) + ({4'd0, int_acc_reg} << 1)
                     + (INT_BITS+4)'(digit);
    assign frac_wide = ({4'd0, frac_acc_reg} << 3) + ({4'd0, frac_acc_reg} << 1)
                     + (FACC_W+4)'(digit);

    always_comb
    begin
        int_acc_next  = int_acc_reg;
        frac_acc_next = frac_acc_reg;
        frac_cnt_next = frac_cnt_reg;
        point_next    = point_reg;
        ovf_next      = ovf_reg;
        if (is_point)
        begin
            point_next = 1'b1;
        end
        else if (is_digit)
        begin
            if (!point_reg)
            begin
                if (|int_wide[INT_BITS+3:INT_BITS])
                begin
                    int_acc_next = '1;    // saturate
                    ovf_next     = 1'b1;
                end
                else
                begin
                    int_acc_next = int_wide[INT_BITS-1:0];
                end
            end
            else if (frac_cnt_reg < CNT_W'(MAX_FRAC_DIGITS))
            begin
                // at most MAX_FRAC_DIGITS digits, so no bits are lost here
                frac_acc_next = frac_wide[FACC_W-1:0];
                frac_cnt_next = frac_cnt_reg + 1'b1;
            end
        end
    end

    assign push = accept && char_chan.last_char;
    assign job  = {ovf_next, int_acc_next, frac_acc_next, frac_cnt_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_acc_reg  <= '0;
            frac_acc_reg <= '0;
            frac_cnt_reg <= '0;
            point_reg    <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else if (accept)
        begin
            if (char_chan.last_char)
            begin
                int_acc_reg  <= '0;
                frac_acc_reg <= '0;
                frac_cnt_reg <= '0;
                point_reg    <= 1'b0;
                ovf_reg      <= 1'b0;
            end
            else
            begin
                int_acc_reg  <= int_acc_next;
                frac_acc_reg <= frac_acc_next;
                frac_cnt_reg <= frac_cnt_next;
                point_reg    <= point_next;
                ovf_reg      <= ovf_next;
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/dtfp_queue.sv
// ----------------------------------------------------------------------------
// dtfp_queue
// Two-entry job queue between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module dtfp_queue #(
    parameter int WIDTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [WIDTH-1:0]  push_data,
    input  wire logic              pop,
    output logic [WIDTH-1:0]       pop_data,
    output dtfp_pkg::q_status_t    q_status
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg,  count_next;

    assign q_status.full  = (count_reg == 2'd2);
    assign q_status.empty = (count_reg == 2'd0);
    assign pop_data       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!q_status.full || pop))
        else $error("job queue overrun");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("job queue underrun");

endmodule

`default_nettype wire

// File: sv/dtfp_back.sv
// ----------------------------------------------------------------------------
// dtfp_back
// Fraction scaling by restoring division (one quotient bit per cycle) and
// the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dtfp_back #(
    parameter int INT_BITS  = 32,
    parameter int FRAC_BITS = 16,
    parameter int FACC_W    = 27,
    parameter int CNT_W     = 4,
    parameter int DIV_W     = 27,
    parameter int JOB_W     = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dtfp_pkg::q_status_t q_status,
    input  wire logic [JOB_W-1:0]  job,
    output logic                   pop,
    dtfp_result_if.source          result_chan
);

    localparam int VALUE_W = INT_BITS + FRAC_BITS;
    localparam int STEP_W  = $clog2(FRAC_BITS);

    dtfp_pkg::back_state_t state_reg, state_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 load;
    logic                 last_step;

    logic [INT_BITS-1:0]  int_reg;
    logic                 ovf_reg;
    logic [DIV_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     div_reg;
    logic [FRAC_BITS-1:0] quo_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic                 out_ovf_reg;

    logic                 job_ovf;
    logic [INT_BITS-1:0]  job_int;
    logic [FACC_W-1:0]    job_facc;
    logic [CNT_W-1:0]     job_cnt;
    logic [DIV_W:0]       shifted;
    logic                 ge;
    logic [DIV_W-1:0]     rem_next;
    logic [VALUE_W-1:0]   value_full;
    logic [VALUE_W-1:0]   value_masked;

    assign {job_ovf, job_int, job_facc, job_cnt} = job;

    assign shifted   = {rem_reg, 1'b0};
    assign ge        = (shifted >= {1'b0, div_reg});
    assign rem_next  = ge ? DIV_W'(shifted - {1'b0, div_reg}) : shifted[DIV_W-1:0];
    assign last_step = (step_reg == STEP_W'(FRAC_BITS - 1));

    assign value_full = {int_reg, quo_reg};

    // bits above 63 read as zero
    always_comb
    begin
        for (int i = 0; i < VALUE_W; i++)
        begin
            value_masked[i] = (i < 64) ? value_full[i] : 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load       = 1'b0;
        case (state_reg)
            dtfp_pkg::BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    state_next = dtfp_pkg::BK_DIV;
                end
            end
            dtfp_pkg::BK_DIV:
            begin
                if (last_step)
                begin
                    state_next = dtfp_pkg::BK_HOLD;
                end
            end
            dtfp_pkg::BK_HOLD:
            begin
                if (!out_valid_reg || result_chan.ready)
                begin
                    load       = 1'b1;
                    state_next = dtfp_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = dtfp_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_chan.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dtfp_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            int_reg  <= job_int;
            ovf_reg  <= job_ovf;
            rem_reg  <= DIV_W'(job_facc);
            div_reg  <= DIV_W'(dtfp_pkg::pow_ten(4'(job_cnt)));
            quo_reg  <= '0;
            step_reg <= '0;
        end
        else if (state_reg == dtfp_pkg::BK_DIV)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= {quo_reg[FRAC_BITS-2:0], ge};
            step_reg <= step_reg + 1'b1;
        end
        if (load)
        begin
            value_reg   <= value_masked;
            out_ovf_reg <= ovf_reg;
        end
    end

    assign result_chan.valid       = out_valid_reg;
    assign result_chan.fixed_value = value_reg;
    assign result_chan.overflowed  = out_ovf_reg;

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtfp_pkg::BK_DIV) |-> (rem_reg < div_reg))
        else $error("division remainder not below divisor");

    a_div_to_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dtfp_pkg::BK_DIV && last_step) |=>
            (state_reg == dtfp_pkg::BK_HOLD))
        else $error("division did not finish after FRAC_BITS steps");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

// File: sv/decimal_text_to_fixed_point_core.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_core
// ASCII decimal string, one character per request, to unsigned fixed point
// UQ(INT_BITS).(FRAC_BITS).
// ----------------------------------------------------------------------------
//
//  channel      dir  handshake     payload
//  char_chan    in   valid/ready   char_code[7:0], last_char
//  result_chan  out  valid/ready   fixed_value[INT_BITS+FRAC_BITS-1:0], overflowed
//
//  Cycles: one character per cycle into the front accumulators while the
//  job queue is not full. A string's result passes through the job queue,
//  the one-bit-per-cycle fraction divider and the back end's hold state.
//  Strings shorter than about FRAC_BITS + 2 characters fill the two-entry
//  job queue and stall char_chan until the divider frees an entry.
//  Reset: rst_n async, low active; clears accumulators, queue and result valid.
//  A stalled result_chan holds the result; the divider stops in its hold state.
//
`default_nettype none

module decimal_text_to_fixed_point_core #(
    parameter int INT_BITS        = 32,
    parameter int FRAC_BITS       = 16,
    parameter int MAX_FRAC_DIGITS = 8
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    dtfp_char_if.sink      char_chan,
    dtfp_result_if.source  result_chan
);

    // Fraction accumulator holds up to MAX_FRAC_DIGITS decimal digits.
    localparam int FACC_W = $clog2(10 ** MAX_FRAC_DIGITS);
    localparam int CNT_W  = $clog2(MAX_FRAC_DIGITS + 1);
    // Divisor is 10^n with n up to MAX_FRAC_DIGITS.
    localparam int DIV_W  = $clog2(10 ** MAX_FRAC_DIGITS + 1);
    // Job: overflow flag, integer part, fraction digits, digit count.
    localparam int JOB_W  = 1 + INT_BITS + FACC_W + CNT_W;

    dtfp_pkg::q_status_t q_status;
    logic                push;
    logic                pop;
    logic [JOB_W-1:0]    push_job;
    logic [JOB_W-1:0]    pop_job;

    // Front end: classifies characters, accumulates, pushes a job per string.
    dtfp_front #(
        .INT_BITS        (INT_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS),
        .FACC_W          (FACC_W),
        .CNT_W           (CNT_W),
        .JOB_W           (JOB_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_chan (char_chan),
        .q_status  (q_status),
        .push      (push),
        .job       (push_job)
    );

    // Decouples string capture from fraction scaling.
    dtfp_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .pop       (pop),
        .pop_data  (pop_job),
        .q_status  (q_status)
    );

    // Back end: floor(F * 2^FRAC_BITS / 10^n), then the output register.
    dtfp_back #(
        .INT_BITS  (INT_BITS),
        .FRAC_BITS (FRAC_BITS),
        .FACC_W    (FACC_W),
        .CNT_W     (CNT_W),
        .DIV_W     (DIV_W),
        .JOB_W     (JOB_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .job         (pop_job),
        .pop         (pop),
        .result_chan (result_chan)
    );

endmodule

`default_nettype wire

// File: dv/dtfp_conversion_checker.sv
// ----------------------------------------------------------------------------
// dtfp_conversion_checker
// Watches the character and result channels of the decimal text to fixed
// point core. It keeps its own accumulators, works out the value of every
// string when that string's last character is accepted, and compares each
// accepted result with the oldest value still owed.
// ----------------------------------------------------------------------------
`default_nettype none

module dtfp_conversion_checker #(
    parameter int INT_BITS        = 32,
    parameter int FRAC_BITS       = 16,
    parameter int MAX_FRAC_DIGITS = 8,
    parameter int VALUE_W         = INT_BITS + FRAC_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               char_valid,
    input  wire logic               char_ready,
    input  wire logic [7:0]         char_code,
    input  wire logic               last_char,
    input  wire logic               res_valid,
    input  wire logic               res_ready,
    input  wire logic [VALUE_W-1:0] fixed_value,
    input  wire logic               overflowed,
    output int                      fail_count,
    output int                      pending_results,
    output int                      results_checked,
    output int                      overflow_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               ovf;
    } conversion_t;

    conversion_t owed_values[$];

    // Accumulators of the string in flight.
    logic [63:0] int_acc;
    logic [63:0] frac_acc;
    int unsigned frac_digits;
    logic        point_seen;
    logic        ovf_sticky;

    int n_fail    = 0;
    int n_checked = 0;
    int n_ovf     = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        n_fail++;
    endtask

    task automatic clear_string();
        int_acc     = '0;
        frac_acc    = '0;
        frac_digits = 0;
        point_seen  = 1'b0;
        ovf_sticky  = 1'b0;
    endtask

    task automatic absorb_char(input logic [7:0] c);
        logic [63:0] next;
        logic [63:0] int_max;
        int_max = (64'd1 << INT_BITS) - 64'd1;
        if (c == dtfp_pkg::ASCII_POINT)
        begin
            point_seen = 1'b1;
        end
        else if (c >= dtfp_pkg::ASCII_ZERO && c <= dtfp_pkg::ASCII_NINE)
        begin
            if (!point_seen)
            begin
                next = int_acc * 64'd10 + 64'(c - dtfp_pkg::ASCII_ZERO);
                if (next > int_max)
                begin
                    int_acc    = int_max;
                    ovf_sticky = 1'b1;
                end
                else
                begin
                    int_acc = next;
                end
            end
            else if (frac_digits < MAX_FRAC_DIGITS)
            begin
                frac_acc = frac_acc * 64'd10 + 64'(c - dtfp_pkg::ASCII_ZERO);
                frac_digits++;
            end
        end
    endtask

    // Fraction bits are floor(F * 2^FRAC_BITS / 10^n), so they never carry.
    function automatic conversion_t close_string();
        conversion_t res;
        logic [63:0] scale;
        logic [63:0] frac_part;
        logic [63:0] full;
        scale = 64'd1;
        for (int i = 0; i < frac_digits && i < 9; i++)
            scale = scale * 64'd10;
        frac_part = (frac_acc << FRAC_BITS) / scale;
        full      = (int_acc << FRAC_BITS) | frac_part;
        res.value = full[VALUE_W-1:0];
        res.ovf   = ovf_sticky;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        conversion_t want;
        if (!rst_n)
        begin
            clear_string();
            owed_values.delete();
        end
        else
        begin
            if (char_valid && char_ready)
            begin
                absorb_char(char_code);
                if (last_char)
                begin
                    owed_values.push_back(close_string());
                    clear_string();
                end
            end
            if (res_valid && res_ready)
            begin
                if (owed_values.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result %h ovf=%b",
                                              fixed_value, overflowed));
                end
                else
                begin
                    want = owed_values.pop_front();
                    if (fixed_value !== want.value)
                        report_mismatch($sformatf("fixed_value %h, expected %h",
                                                  fixed_value, want.value));
                    if (overflowed !== want.ovf)
                        report_mismatch($sformatf("overflowed %b, expected %b",
                                                  overflowed, want.ovf));
                    n_checked++;
                    if (want.ovf)
                        n_ovf++;
                end
            end
        end
        fail_count      <= n_fail;
        pending_results <= owed_values.size();
        results_checked <= n_checked;
        overflow_count  <= n_ovf;
    end

endmodule

`default_nettype wire

// File: dv/tb_decimal_text_to_fixed_point_core.sv
// ----------------------------------------------------------------------------
// tb_decimal_text_to_fixed_point_core
// Streams decimal strings, one character per request, into the core: a few
// hand-picked strings first, then random numbers and noise under changing
// sender and receiver pacing. A separate checker predicts every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_decimal_text_to_fixed_point_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int INT_BITS        = 32;
    localparam int FRAC_BITS       = 16;
    localparam int MAX_FRAC_DIGITS = 8;
    localparam int VALUE_W         = INT_BITS + FRAC_BITS;

    // Watchdog limit, with lots of headroom over the slowest legal run.
    localparam int LIMIT_CYCLES    = 400000;
    localparam int TAIL_CYCLES     = 2 * (FRAC_BITS + 3);
    localparam int PHASE_CHARS     = 200;

    typedef logic [7:0] text_t[$];

    logic clk;
    logic rst_n;

    dtfp_char_if                       char_chan();
    dtfp_result_if #(.VALUE_W(VALUE_W)) result_chan();

    int idle_pct    = 0;   // chance per cycle that the sender holds back
    int stall_pct   = 0;   // chance per cycle that the receiver is not ready
    int chars_sent  = 0;
    int strings_sent = 0;

    int fail_count;
    int pending_results;
    int results_checked;
    int overflow_count;

    decimal_text_to_fixed_point_core #(
        .INT_BITS       (INT_BITS),
        .FRAC_BITS      (FRAC_BITS),
        .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_chan  (char_chan),
        .result_chan(result_chan)
    );

    dtfp_conversion_checker #(
        .INT_BITS       (INT_BITS),
        .FRAC_BITS      (FRAC_BITS),
        .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS),
        .VALUE_W        (VALUE_W)
    ) conversion_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .char_valid     (char_chan.valid),
        .char_ready     (char_chan.ready),
        .char_code      (char_chan.char_code),
        .last_char      (char_chan.last_char),
        .res_valid      (result_chan.valid),
        .res_ready      (result_chan.ready),
        .fixed_value    (result_chan.fixed_value),
        .overflowed     (result_chan.overflowed),
        .fail_count     (fail_count),
        .pending_results(pending_results),
        .results_checked(results_checked),
        .overflow_count (overflow_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop if the core wedges or a result never shows up.
    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("FAIL");
        $finish;
    end

    // Receiver pacing: one fresh draw per cycle, no stall when stall_pct is 0.
    // Held low while reset is applied.
    always @(posedge clk)
    begin
        result_chan.ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end

    // One character request. Valid stays high across back-to-back requests;
    // it only drops while the sender decides to idle or drain_results waits.
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < idle_pct)
        begin
            char_chan.valid <= 1'b0;
            @(posedge clk);
        end
        char_chan.valid     <= 1'b1;
        char_chan.char_code <= c;
        char_chan.last_char <= last;
        do
            @(posedge clk);
        while (!char_chan.ready);
        chars_sent++;
    endtask

    task automatic send_text(input text_t t);
        foreach (t[i])
            send_char(t[i], i == t.size() - 1);
        strings_sent++;
    endtask

    task automatic send_ascii(input string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        send_text(t);
    endtask

    // Sender goes quiet until every owed result has come back. The checker's
    // count is registered and lags the handshake, hence the edge before the first look.
    task automatic drain_results();
        char_chan.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_results != 0);
    endtask

    task automatic push_digits(inout text_t t, input int n);
        for (int i = 0; i < n; i++)
            t.push_back(dtfp_pkg::ASCII_ZERO + 8'($urandom_range(9)));
    endtask

    // Mostly well-formed numbers with random digits, some right at the
    // integer saturation edge, the rest byte noise with stray points.
    task automatic send_random_string();
        text_t t;
        string prefix;
        int    pick;
        int    n;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            // 429496729x: saturates for x above 5
            prefix = "429496729";
            for (int i = 0; i < prefix.len(); i++)
                t.push_back(prefix[i]);
            push_digits(t, 1);
            if ($urandom_range(1))
            begin
                t.push_back(dtfp_pkg::ASCII_POINT);
                push_digits(t, $urandom_range(0, 10));
            end
        end
        else if (pick < 75)
        begin
            // Up to 12 integer digits reaches past 32 bits; up to 11
            // fraction digits runs past the fraction digit cap.
            push_digits(t, $urandom_range(0, 12));
            if ($urandom_range(3) != 0)
            begin
                t.push_back(dtfp_pkg::ASCII_POINT);
                push_digits(t, $urandom_range(0, 11));
            end
            // Occasionally splice in a stray byte (a second point or junk).
            if ($urandom_range(9) == 0)
            begin
                n = $urandom_range(t.size());
                t.insert(n, $urandom_range(1) ? dtfp_pkg::ASCII_POINT
                                              : 8'($urandom_range(255)));
            end
        end
        else
        begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                t.push_back($urandom_range(4) == 0 ? dtfp_pkg::ASCII_POINT
                                                   : 8'($urandom_range(255)));
        end
        if (t.size() == 0)
            t.push_back(8'($urandom_range(255)));
        send_text(t);
    endtask

    initial
    begin
        rst_n                 = 1'b0;
        char_chan.valid       = 1'b0;
        char_chan.char_code   = '0;
        char_chan.last_char   = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings: lone zero, largest integer that still fits,
        // bytes just outside the digit range plus NUL ahead of a 7, a bare fraction,
        // a repeated point, and a string with no digits at all.
        send_ascii("0");
        send_ascii("4294967295");
        send_text('{8'h2F, 8'h3A, 8'h00, 8'h37});
        send_ascii(".5");
        send_ascii("1..2");
        send_text('{8'hFF});
        drain_results();

        // Random phases: free flow, idle sender, stalling receiver, both.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 45;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 45;
                end
                default:
                begin
                    idle_pct  = 13;
                    stall_pct = 13;
                end
            endcase
            n_target(phase);
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d characters in %0d strings over four pacing phases.",
                 chars_sent, strings_sent);
        $display("Checked %0d results, %0d of them saturated.",
                 results_checked, overflow_count);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Keep sending random strings until this phase's character budget is spent.
    task automatic n_target(input int phase);
        int goal;
        goal = chars_sent + PHASE_CHARS;
        while (chars_sent < goal)
            send_random_string();
    endtask

endmodule

`default_nettype wire

// File: filelist.f
sv/dtfp_pkg.sv
sv/dtfp_ifs.sv
sv/dtfp_front.sv
sv/dtfp_queue.sv
sv/dtfp_back.sv
sv/decimal_text_to_fixed_point_core.sv
dv/dtfp_conversion_checker.sv
dv/tb_decimal_text_to_fixed_point_core.sv
